FILE: design/pfr_pkg.sv
// Shared types and codes of the page frame buffer rasterizer.
package pfr_pkg;

   localparam logic [1:0] MODE_PIXEL  = 2'd0;
   localparam logic [1:0] MODE_LINE   = 2'd1;
   localparam logic [1:0] MODE_CIRCLE = 2'd2;
   localparam logic [1:0] MODE_READ   = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DRAW,
      ST_RD_ISSUE,
      ST_RD_DATA,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      RS_IDLE,
      RS_LINE,
      RS_LINE_END,
      RS_CIRC_AXIS,
      RS_CIRC_TEST,
      RS_CIRC_OCT
   } raster_state_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] x_a;
      logic [7:0] y_a;
      logic [6:0] x_b;
      logic [5:0] y_b;
      logic [6:0] radius;
      logic       ink;
   } cmd_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] x;
      logic [7:0] y;
      logic       ink;
   } plot_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } store_status_type;

endpackage

FILE: design/page_framebuffer_rasterizer.sv
// Top level: command sequencing, readback and result register of the page frame buffer.
// A pixel plots one pixel, a line max(|dx|,|dy|) + 1 pixels, a readback returns one byte,
// and a circle 4 axis pixels plus 8 per midpoint iteration (about 0.71 * radius + 1 of them).
// Throughput is one pixel per cycle but in the circle's test state, set by the single
// read-modify-write port of the store. After reset the store is cleared one byte a cycle,
// all SCREEN_WIDTH*PAGE_COUNT bytes, with req_stall high during that pass.
module page_framebuffer_rasterizer #(
   parameter int SCREEN_WIDTH = 84,
   parameter int PAGE_COUNT   = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_x_a,
   input  logic [7:0] req_y_a,
   input  logic [6:0] req_x_b,
   input  logic [5:0] req_y_b,
   input  logic [6:0] req_radius,
   input  logic       req_ink,
   input  logic [8:0] req_read_address,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_byte
);

   localparam int DEPTH = SCREEN_WIDTH * PAGE_COUNT;
   localparam int AW    = $clog2(DEPTH);

   pfr_pkg::state_type        state_ff, state_in;
   pfr_pkg::cmd_type          cmd;
   pfr_pkg::plot_type         point;
   pfr_pkg::store_status_type status;

   logic       accept, raster_busy, rd_req, rsp_load;
   logic [7:0] rd_data;
   logic [8:0] rd_addr_ff;
   logic       rd_ok_ff;
   logic [7:0] result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_read_byte_ff;

   assign accept = req_valid && !req_stall;

   assign cmd.mode   = req_mode;
   assign cmd.x_a    = req_x_a;
   assign cmd.y_a    = req_y_a;
   assign cmd.x_b    = req_x_b;
   assign cmd.y_b    = req_y_b;
   assign cmd.radius = req_radius;
   assign cmd.ink    = req_ink;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfr_pkg::ST_CLEAR: if (!status.clearing) state_in = pfr_pkg::ST_IDLE;
         pfr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_mode == pfr_pkg::MODE_READ) ? pfr_pkg::ST_RD_ISSUE
                                                           : pfr_pkg::ST_DRAW;
            end
         end
         pfr_pkg::ST_DRAW:
            if (!raster_busy && !status.busy) state_in = pfr_pkg::ST_DONE;
         pfr_pkg::ST_RD_ISSUE: state_in = pfr_pkg::ST_RD_DATA;
         pfr_pkg::ST_RD_DATA:  state_in = pfr_pkg::ST_DONE;
         pfr_pkg::ST_DONE:     if (!rsp_valid_ff || !rsp_stall) state_in = pfr_pkg::ST_IDLE;
         default:              state_in = pfr_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall = 1'b1;
      rd_req    = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         pfr_pkg::ST_IDLE:     req_stall = 1'b0;
         pfr_pkg::ST_RD_ISSUE: rd_req    = 1'b1;
         pfr_pkg::ST_DONE:     rsp_load  = !rsp_valid_ff || !rsp_stall;
         default:              req_stall = 1'b1;
      endcase
   end

   always_comb begin
      result_in = result_ff;
      if (accept) begin
         result_in = 8'd0;
      end else if (state_ff == pfr_pkg::ST_RD_DATA) begin
         result_in = rd_ok_ff ? rd_data : 8'd0;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfr_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
      if (accept) begin
         rd_addr_ff <= req_read_address;
         rd_ok_ff   <= {2'b0, req_read_address} < 11'(DEPTH);
      end
      if (rsp_load) begin
         rsp_read_byte_ff <= result_ff;
      end
   end

   pfr_raster u_raster (
      .clock(clock),
      .reset(reset),
      .start(accept && (req_mode != pfr_pkg::MODE_READ)),
      .cmd  (cmd),
      .point(point),
      .busy (raster_busy)
   );

   pfr_store #(
      .SCREEN_WIDTH(SCREEN_WIDTH),
      .PAGE_COUNT  (PAGE_COUNT)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .point  (point),
      .rd_req (rd_req),
      .rd_addr(AW'(rd_addr_ff)),
      .rd_data(rd_data),
      .status (status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_read_byte_ff;

endmodule

FILE: design/pfr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module pfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 504
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/pfr_store.sv
// Frame store: clearing pass, pixel read-modify-write pipeline and byte readback.
module pfr_store #(
   parameter int SCREEN_WIDTH = 84,
   parameter int PAGE_COUNT   = 6
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  pfr_pkg::plot_type                            point,
   input  logic                                         rd_req,
   input  logic [$clog2(SCREEN_WIDTH*PAGE_COUNT)-1:0]   rd_addr,
   output logic [7:0]                                   rd_data,
   output pfr_pkg::store_status_type                    status
);

   localparam int DEPTH = SCREEN_WIDTH * PAGE_COUNT;
   localparam int AW    = $clog2(DEPTH);

   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   logic          s2_valid_ff;
   logic [AW-1:0] s2_addr_ff;
   logic [2:0]    s2_bit_ff;
   logic          s2_ink_ff;

   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic [7:0]    fwd_data_ff;

   logic          on_screen;
   logic [AW-1:0] pt_addr;
   logic [7:0]    old_byte, new_byte, mask;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    wdata, ram_rdata;

   assign on_screen = point.valid
                      && ({1'b0, point.x} < 9'(SCREEN_WIDTH))
                      && ({1'b0, point.y} < 9'(8 * PAGE_COUNT));
   assign pt_addr   = AW'(int'(point.y[7:3]) * SCREEN_WIDTH + int'(point.x));

   // A byte written in the previous cycle is not yet visible at the read port.
   assign old_byte = (fwd_valid_ff && (fwd_addr_ff == s2_addr_ff)) ? fwd_data_ff : ram_rdata;
   assign mask     = 8'(1) << s2_bit_ff;
   assign new_byte = s2_ink_ff ? (old_byte | mask) : (old_byte & ~mask);

   always_comb begin
      we    = s2_valid_ff;
      waddr = s2_addr_ff;
      wdata = new_byte;
      if (clearing_ff) begin
         we    = 1'b1;
         waddr = clr_cnt_ff;
         wdata = 8'd0;
      end
      raddr = rd_req ? rd_addr : pt_addr;
   end

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         s2_valid_ff  <= on_screen;
         fwd_valid_ff <= s2_valid_ff;
      end
      s2_addr_ff  <= pt_addr;
      s2_bit_ff   <= point.y[2:0];
      s2_ink_ff   <= point.ink;
      fwd_addr_ff <= s2_addr_ff;
      fwd_data_ff <= new_byte;
   end

   pfr_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(ram_rdata)
   );

   assign rd_data         = ram_rdata;
   assign status.clearing = clearing_ff;
   assign status.busy     = s2_valid_ff;

endmodule

FILE: design/pfr_raster.sv
// Pixel sequencer: point, line or midpoint circle, a pixel a cycle but in RS_CIRC_TEST.
module pfr_raster (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pfr_pkg::cmd_type  cmd,
   output pfr_pkg::plot_type point,
   output logic              busy
);

   pfr_pkg::raster_state_type state_ff, state_in;

   logic              ink_ff, ink_in;
   logic [7:0]        xa_ff, xa_in, ya_ff, ya_in;
   logic [7:0]        end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic              x_neg_ff, x_neg_in, y_neg_ff, y_neg_in, x_major_ff, x_major_in;
   logic [7:0]        maj_ff, maj_in, mnr_ff, mnr_in;
   logic [7:0]        i_ff, i_in, q_ff, q_in, r_ff, r_in;
   logic [6:0]        cr_ff, cr_in, cx_ff, cx_in, cy_ff, cy_in;
   logic signed [11:0] f_ff, f_in;
   logic [2:0]        idx_ff, idx_in;

   logic [7:0] xb8, yb8, spx, spy, x_off, y_off, a_off, b_off;
   logic       sx_neg, sy_neg, sx_major;
   logic [8:0] r_sum;
   logic       line_last;
   logic [6:0] y_dec;
   logic signed [11:0] f_a;

   assign xb8      = {1'b0, cmd.x_b};
   assign yb8      = {2'b0, cmd.y_b};
   assign sx_neg   = xb8 < cmd.x_a;
   assign sy_neg   = yb8 < cmd.y_a;
   assign spx      = sx_neg ? (cmd.x_a - xb8) : (xb8 - cmd.x_a);
   assign spy      = sy_neg ? (cmd.y_a - yb8) : (yb8 - cmd.y_a);
   assign sx_major = spx >= spy;

   assign r_sum     = {1'b0, r_ff} + {1'b0, mnr_ff};
   assign line_last = ({1'b0, i_ff} + 9'd1) == {1'b0, maj_ff};
   assign x_off     = x_major_ff ? i_ff : q_ff;
   assign y_off     = x_major_ff ? q_ff : i_ff;
   assign a_off     = idx_ff[2] ? {1'b0, cy_ff} : {1'b0, cx_ff};
   assign b_off     = idx_ff[2] ? {1'b0, cx_ff} : {1'b0, cy_ff};
   assign y_dec     = cy_ff - 7'd1;
   assign f_a       = (f_ff >= 0) ? (f_ff - $signed({4'b0, y_dec, 1'b0})) : f_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfr_pkg::RS_IDLE: begin
            if (start) begin
               case (cmd.mode)
                  pfr_pkg::MODE_LINE:
                     state_in = ((sx_major ? spx : spy) == 8'd0) ? pfr_pkg::RS_LINE_END
                                                                 : pfr_pkg::RS_LINE;
                  pfr_pkg::MODE_CIRCLE: state_in = pfr_pkg::RS_CIRC_AXIS;
                  default:              state_in = pfr_pkg::RS_LINE_END;
               endcase
            end
         end
         pfr_pkg::RS_LINE:      if (line_last) state_in = pfr_pkg::RS_LINE_END;
         pfr_pkg::RS_LINE_END:  state_in = pfr_pkg::RS_IDLE;
         pfr_pkg::RS_CIRC_AXIS: if (idx_ff == 3'd3) state_in = pfr_pkg::RS_CIRC_TEST;
         pfr_pkg::RS_CIRC_TEST:
            state_in = (cx_ff < cy_ff) ? pfr_pkg::RS_CIRC_OCT : pfr_pkg::RS_IDLE;
         pfr_pkg::RS_CIRC_OCT:  if (idx_ff == 3'd7) state_in = pfr_pkg::RS_CIRC_TEST;
         default:               state_in = pfr_pkg::RS_IDLE;
      endcase
   end

   // Outputs. The circle center sits in xa/ya, its running offsets in cx/cy.
   always_comb begin
      point.valid = 1'b0;
      point.x     = 8'd0;
      point.y     = 8'd0;
      point.ink   = ink_ff;
      busy        = state_ff != pfr_pkg::RS_IDLE;
      case (state_ff)
         pfr_pkg::RS_LINE: begin
            point.valid = 1'b1;
            point.x     = x_neg_ff ? (xa_ff - x_off) : (xa_ff + x_off);
            point.y     = y_neg_ff ? (ya_ff - y_off) : (ya_ff + y_off);
         end
         pfr_pkg::RS_LINE_END: begin
            point.valid = 1'b1;
            point.x     = end_x_ff;
            point.y     = end_y_ff;
         end
         pfr_pkg::RS_CIRC_AXIS: begin
            point.valid = 1'b1;
            case (idx_ff[1:0])
               2'd0:    begin point.x = xa_ff; point.y = ya_ff + {1'b0, cr_ff}; end
               2'd1:    begin point.x = xa_ff; point.y = ya_ff - {1'b0, cr_ff}; end
               2'd2:    begin point.x = xa_ff + {1'b0, cr_ff}; point.y = ya_ff; end
               default: begin point.x = xa_ff - {1'b0, cr_ff}; point.y = ya_ff; end
            endcase
         end
         pfr_pkg::RS_CIRC_OCT: begin
            point.valid = 1'b1;
            point.x     = idx_ff[0] ? (xa_ff - a_off) : (xa_ff + a_off);
            point.y     = idx_ff[1] ? (ya_ff - b_off) : (ya_ff + b_off);
         end
         default: begin
            point.valid = 1'b0;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      ink_in     = ink_ff;
      xa_in      = xa_ff;
      ya_in      = ya_ff;
      end_x_in   = end_x_ff;
      end_y_in   = end_y_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      x_major_in = x_major_ff;
      maj_in     = maj_ff;
      mnr_in     = mnr_ff;
      i_in       = i_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      cr_in      = cr_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      f_in       = f_ff;
      idx_in     = idx_ff;
      case (state_ff)
         pfr_pkg::RS_IDLE: begin
            ink_in     = cmd.ink;
            xa_in      = cmd.x_a;
            ya_in      = cmd.y_a;
            end_x_in   = (cmd.mode == pfr_pkg::MODE_LINE) ? xb8 : cmd.x_a;
            end_y_in   = (cmd.mode == pfr_pkg::MODE_LINE) ? yb8 : cmd.y_a;
            x_neg_in   = sx_neg;
            y_neg_in   = sy_neg;
            x_major_in = sx_major;
            maj_in     = sx_major ? spx : spy;
            mnr_in     = sx_major ? spy : spx;
            i_in       = 8'd0;
            q_in       = 8'd0;
            r_in       = 8'd0;
            cr_in      = cmd.radius;
            cx_in      = 7'd0;
            cy_in      = cmd.radius;
            f_in       = 12'sd1 - $signed({5'b0, cmd.radius});
            idx_in     = 3'd0;
         end
         pfr_pkg::RS_LINE: begin
            i_in = i_ff + 8'd1;
            // The minor span never exceeds the major span, so one subtraction suffices.
            if (r_sum >= {1'b0, maj_ff}) begin
               r_in = 8'(r_sum - {1'b0, maj_ff});
               q_in = q_ff + 8'd1;
            end else begin
               r_in = r_sum[7:0];
            end
         end
         pfr_pkg::RS_CIRC_AXIS: begin
            idx_in = (idx_ff == 3'd3) ? 3'd0 : idx_ff + 3'd1;
         end
         pfr_pkg::RS_CIRC_TEST: begin
            idx_in = 3'd0;
            if (cx_ff < cy_ff) begin
               cy_in = (f_ff >= 0) ? y_dec : cy_ff;
               cx_in = cx_ff + 7'd1;
               f_in  = f_a + $signed({4'b0, cx_ff + 7'd1, 1'b1});
            end
         end
         pfr_pkg::RS_CIRC_OCT: begin
            idx_in = idx_ff + 3'd1;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfr_pkg::RS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ink_ff     <= ink_in;
      xa_ff      <= xa_in;
      ya_ff      <= ya_in;
      end_x_ff   <= end_x_in;
      end_y_ff   <= end_y_in;
      x_neg_ff   <= x_neg_in;
      y_neg_ff   <= y_neg_in;
      x_major_ff <= x_major_in;
      maj_ff     <= maj_in;
      mnr_ff     <= mnr_in;
      i_ff       <= i_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      cr_ff      <= cr_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      f_ff       <= f_in;
      idx_ff     <= idx_in;
   end

endmodule

FILE: sim/pfr_checker.sv
// Checker for the page frame buffer rasterizer: shadow frame store, prediction and comparison.
module pfr_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_x_a,
   input  logic [7:0] req_y_a,
   input  logic [6:0] req_x_b,
   input  logic [5:0] req_y_b,
   input  logic [6:0] req_radius,
   input  logic       req_ink,
   input  logic [8:0] req_read_address,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_read_byte,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH = 84;
   localparam int ROWS = 48;
   localparam int STORE_BYTES = 504;

   logic [7:0] shadow_store [STORE_BYTES];
   logic [7:0] expected_bytes [$];

   function automatic void plot_pixel(int x, int y, logic ink);
      int idx;
      if (x < 0 || y < 0 || x >= WIDTH || y >= ROWS) return;
      idx = (y >> 3) * WIDTH + x;
      shadow_store[idx][y & 7] = ink;
   endfunction

   function automatic void plot_wrapped(int x, int y, logic ink);
      plot_pixel(x & 255, y & 255, ink);
   endfunction

   function automatic void draw_line(int x1, int y1, int x2, int y2, logic ink);
      int sx, sy, spx, spy;
      sx = (x2 >= x1) ? 1 : -1;
      sy = (y2 >= y1) ? 1 : -1;
      spx = (x2 >= x1) ? x2 - x1 : x1 - x2;
      spy = (y2 >= y1) ? y2 - y1 : y1 - y2;
      if (spx >= spy) begin
         for (int i = 0; i < spx; i++) plot_pixel(x1 + sx * i, y1 + sy * ((spy * i) / spx), ink);
      end else begin
         for (int i = 0; i < spy; i++) plot_pixel(x1 + sx * ((spx * i) / spy), y1 + sy * i, ink);
      end
      plot_pixel(x2, y2, ink);
   endfunction

   function automatic void draw_circle(int cx, int cy, int r, logic ink);
      int f, step_x, step_y, x, y;
      f = 1 - r;
      step_x = 1;
      step_y = -2 * r;
      x = 0;
      y = r;
      plot_wrapped(cx, cy + r, ink);
      plot_wrapped(cx, cy - r, ink);
      plot_wrapped(cx + r, cy, ink);
      plot_wrapped(cx - r, cy, ink);
      while (x < y) begin
         if (f >= 0) begin
            y--;
            step_y += 2;
            f += step_y;
         end
         x++;
         step_x += 2;
         f += step_x;
         plot_wrapped(cx + x, cy + y, ink);
         plot_wrapped(cx - x, cy + y, ink);
         plot_wrapped(cx + x, cy - y, ink);
         plot_wrapped(cx - x, cy - y, ink);
         plot_wrapped(cx + y, cy + x, ink);
         plot_wrapped(cx - y, cy + x, ink);
         plot_wrapped(cx + y, cy - x, ink);
         plot_wrapped(cx - y, cy - x, ink);
      end
   endfunction

   function automatic logic [7:0] apply_command(logic [1:0] mode, int xa, int ya, int xb,
                                                int yb, int rad, logic ink, int addr);
      case (mode)
         pfr_pkg::MODE_PIXEL: plot_pixel(xa, ya, ink);
         pfr_pkg::MODE_LINE: draw_line(xa, ya, xb, yb, ink);
         pfr_pkg::MODE_CIRCLE: draw_circle(xa, ya, rad, ink);
         default: begin
            if (addr < STORE_BYTES) return shadow_store[addr];
         end
      endcase
      return 8'd0;
   endfunction

   assign pending_count = expected_bytes.size();

   initial begin
      fail_count = 0;
      foreach (shadow_store[i]) shadow_store[i] = 8'd0;
   end

   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_bytes.push_back(apply_command(req_mode, req_x_a, req_y_a, req_x_b,
               req_y_b, req_radius, req_ink, req_read_address));
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected result, read_byte %h", $realtime, rsp_read_byte);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (want !== rsp_read_byte) begin
                  $display("%0t: read_byte expected %h actual %h", $realtime, want,
                           rsp_read_byte);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

FILE: sim/tb_top.sv
// Testbench top: stimulus, stall generation and verdict for the page frame buffer rasterizer.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_mode = pfr_pkg::MODE_PIXEL;
   logic [7:0] req_x_a = 0;
   logic [7:0] req_y_a = 0;
   logic [6:0] req_x_b = 0;
   logic [5:0] req_y_b = 0;
   logic [6:0] req_radius = 0;
   logic req_ink = 0;
   logic [8:0] req_read_address = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [7:0] rsp_read_byte;
   int fail_count, pending_count;
   bit stimulus_done = 0;
   bit hold_request = 0;

   always #6 clock = ~clock;

   page_framebuffer_rasterizer uut (.*);

   pfr_checker checker_i (.*);

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Valid stays high between back-to-back transactions; it drops only for a gap.
   task automatic send_command(logic [1:0] mode, logic [7:0] xa, logic [7:0] ya,
                               logic [6:0] xb, logic [5:0] yb, logic [6:0] rad,
                               logic ink, logic [8:0] addr, bit no_gap);
      int gap;
      gap = no_gap ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_x_a <= xa;
      req_y_a <= ya;
      req_x_b <= xb;
      req_y_b <= yb;
      req_radius <= rad;
      req_ink <= ink;
      req_read_address <= addr;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random(bit no_gap);
      int kind;
      logic [7:0] xa, ya;
      logic [6:0] rad;
      kind = $urandom_range(0, 9);
      xa = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 90));
      ya = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 52));
      rad = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 30));
      if (kind < 3)
         send_command(pfr_pkg::MODE_PIXEL, xa, ya, 7'($urandom), 6'($urandom), 7'($urandom),
                      1'($urandom), 9'($urandom), no_gap);
      else if (kind < 5)
         send_command(pfr_pkg::MODE_LINE, 8'($urandom_range(0, 90)), 8'($urandom_range(0, 52)),
                      7'($urandom_range(0, 83)), 6'($urandom_range(0, 47)), 7'($urandom),
                      1'($urandom), 9'($urandom), no_gap);
      else if (kind < 6)
         send_command(pfr_pkg::MODE_CIRCLE, xa, ya, 7'($urandom), 6'($urandom), rad,
                      1'($urandom), 9'($urandom), no_gap);
      else
         send_command(pfr_pkg::MODE_READ, 8'($urandom), 8'($urandom), 7'($urandom),
                      6'($urandom), 7'($urandom), 1'($urandom),
                      ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 503)),
                      no_gap);
   endtask

   // Result side: random stalls, plus one long hold-off while requests keep coming.
   initial begin
      @(negedge clock);
      while (!stimulus_done) begin
         if (hold_request) begin
            rsp_stall <= 1;
            repeat (400) @(negedge clock);
            hold_request = 0;
         end else if ($urandom_range(0, 30) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(10, 50)) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
            @(negedge clock);
         end
      end
      rsp_stall <= 0;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: extremes, every mode, off-screen pixels and out-of-range reads.
      send_command(pfr_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 1, 0, 0);
      send_command(pfr_pkg::MODE_PIXEL, 83, 47, 0, 0, 0, 1, 0, 0);
      send_command(pfr_pkg::MODE_PIXEL, 84, 10, 127, 63, 127, 1, 511, 0);
      send_command(pfr_pkg::MODE_PIXEL, 10, 48, 0, 0, 0, 1, 0, 0);
      send_command(pfr_pkg::MODE_PIXEL, 255, 255, 0, 0, 0, 1, 0, 0);
      send_command(pfr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      send_command(pfr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 503, 0);
      send_command(pfr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 504, 0);
      send_command(pfr_pkg::MODE_READ, 255, 255, 127, 63, 127, 1, 511, 0);
      send_command(pfr_pkg::MODE_LINE, 0, 0, 83, 47, 0, 1, 0, 0);
      send_command(pfr_pkg::MODE_LINE, 83, 0, 0, 47, 0, 1, 0, 0);
      send_command(pfr_pkg::MODE_LINE, 40, 20, 40, 20, 0, 1, 0, 0);
      send_command(pfr_pkg::MODE_LINE, 255, 255, 0, 0, 0, 1, 0, 0);
      send_command(pfr_pkg::MODE_LINE, 0, 47, 83, 47, 0, 0, 0, 0);
      send_command(pfr_pkg::MODE_LINE, 10, 40, 12, 2, 0, 1, 0, 0);
      send_command(pfr_pkg::MODE_CIRCLE, 42, 24, 0, 0, 0, 1, 0, 0);
      send_command(pfr_pkg::MODE_CIRCLE, 42, 24, 0, 0, 20, 1, 0, 0);
      send_command(pfr_pkg::MODE_CIRCLE, 0, 0, 0, 0, 10, 1, 0, 0);
      send_command(pfr_pkg::MODE_CIRCLE, 255, 255, 0, 0, 127, 1, 0, 0);
      send_command(pfr_pkg::MODE_CIRCLE, 42, 24, 0, 0, 20, 0, 0, 0);
      send_command(pfr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 3 * 84 + 62, 0);
      for (int i = 0; i < 1580; i++) begin
         if (i == 700) hold_request = 1;
         send_random(hold_request);
      end
      req_valid <= 0;
      stimulus_done = 1;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   initial begin
      #100ms;
      $display("tb_top failed");
      $finish;
   end
endmodule

FILE: page_framebuffer_rasterizer.f
design/pfr_pkg.sv
design/pfr_ram.sv
design/pfr_store.sv
design/pfr_raster.sv
design/page_framebuffer_rasterizer.sv
sim/pfr_checker.sv
sim/tb_top.sv
